[src/lrle_pkg.sv]
// ----------------------------------------------------------------------------
// lrle_pkg
// shared types, character codes and defaults for the run-length body decoder
// ----------------------------------------------------------------------------
package lrle_pkg;

   localparam int DEFAULT_COORD_BITS = 20;
   localparam int DEFAULT_COUNT_BITS = 16;
   localparam int TOTAL_BITS         = 32;
   localparam int BYTE_BITS          = 8;
   localparam int DIGIT_BITS         = 4;

   localparam logic [TOTAL_BITS-1:0] LIMIT_RESET = '1;
   localparam logic [DIGIT_BITS-1:0] RADIX       = 4'd10;

   localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_CR      = 8'h0d;
   localparam logic [BYTE_BITS-1:0] CHAR_LF      = 8'h0a;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHAR_DEAD    = 8'h62;  // b
   localparam logic [BYTE_BITS-1:0] CHAR_DOT     = 8'h2e;
   localparam logic [BYTE_BITS-1:0] CHAR_ALIVE   = 8'h6f;  // o
   localparam logic [BYTE_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_BITS-1:0] CHAR_UPPER_B = 8'h42;
   localparam logic [BYTE_BITS-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [BYTE_BITS-1:0] CHAR_ROW     = 8'h24;  // $
   localparam logic [BYTE_BITS-1:0] CHAR_END     = 8'h21;  // !

   typedef enum logic [2:0] {
      KIND_SPACE,
      KIND_DIGIT,
      KIND_BLANK,
      KIND_COUNTED,
      KIND_UNCOUNTED,
      KIND_NEWROW,
      KIND_END,
      KIND_OTHER
   } char_kind_type;

   typedef struct packed {
      char_kind_type         kind;
      logic [DIGIT_BITS-1:0] digit;
   } char_class_type;

   typedef enum logic [1:0] {
      EV_RUN      = 2'd0,
      EV_OK       = 2'd1,
      EV_TOO_MANY = 2'd2,
      EV_NO_END   = 2'd3
   } event_type;

endpackage

[src/life_rle_body_decoder.sv]
// ----------------------------------------------------------------------------
// life_rle_body_decoder
// run-length pattern body decoder; unless rsp stalls, one character per cycle
// ----------------------------------------------------------------------------
// The req channel carries one body character per request in req_tdata, with
// req_tlast on the final character of the data. Every request goes into an
// input register; once the output register is free or being drained, a short
// decode updates the count, cursor and live total and, when the character
// produces one, loads a result into the output register. A result thus passes
// the input register and then the output register before rsp_tvalid rises.
// Throughput is one character per cycle, held by the combinational decode; the
// input register keeps taking requests as long as each result is drained.
// rsp_tuser gives the event (run, ok, too many cells, no terminator) and
// rsp_tdata the run column, row, length and counted live total.
// A stalled rsp channel holds its result; once the input register also fills,
// req_tready drops until the result is taken.
// The csr channel writes the live cell limit and is always ready; write it
// only while no request is in flight.
// Reset (synchronous, active high) clears cursor, count, total and the done
// flag, empties both registers and sets the limit to all ones.
// ----------------------------------------------------------------------------
module life_rle_body_decoder #(
   parameter int COORD_BITS = lrle_pkg::DEFAULT_COORD_BITS,
   parameter int COUNT_BITS = lrle_pkg::DEFAULT_COUNT_BITS,
   localparam int DATA_BITS  = 2 * COORD_BITS + COUNT_BITS + lrle_pkg::TOTAL_BITS,
   localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrle_pkg::BYTE_BITS-1:0]      req_tdata,   // data_byte
   input  logic                                req_tlast,   // last_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // run_x, run_y, run_length, live_total, zero pad
   output logic [TDATA_BITS-1:0]               rsp_tdata,
   output logic [1:0]                          rsp_tuser,   // event_res
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrle_pkg::TOTAL_BITS-1:0]     csr_wdata    // live_limit
);

   logic                             in_valid_ff, in_valid_in;
   logic [lrle_pkg::BYTE_BITS-1:0]   in_byte_ff;
   logic                             in_last_ff;
   logic [lrle_pkg::TOTAL_BITS-1:0]  live_limit_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]             rsp_data_ff;
   lrle_pkg::event_type              rsp_event_ff;

   logic                             step;
   lrle_pkg::char_class_type         char_class;
   logic                             emit;
   lrle_pkg::event_type              event_res;
   logic [COORD_BITS-1:0]            run_x, run_y;
   logic [COUNT_BITS-1:0]            run_length;
   logic [lrle_pkg::TOTAL_BITS-1:0]  live_total;

   // decode advances when the output register is free or being drained
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !step);
   assign rsp_valid_in = (step && emit) || (rsp_valid_ff && !rsp_tready);

   lrle_classify u_classify (
      .data_byte  (in_byte_ff),
      .char_class (char_class)
   );

   lrle_core #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .char_class (char_class),
      .step_last  (in_last_ff),
      .live_limit (live_limit_ff),
      .emit       (emit),
      .event_res  (event_res),
      .run_x      (run_x),
      .run_y      (run_y),
      .run_length (run_length),
      .live_total (live_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         live_limit_ff <= lrle_pkg::LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) live_limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && emit) begin
         rsp_data_ff  <= {live_total, run_length, run_y, run_x};
         rsp_event_ff <= event_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_data_ff);
   assign rsp_tuser  = rsp_event_ff;

endmodule

[src/lrle_classify.sv]
// ----------------------------------------------------------------------------
// lrle_classify
// sorts one pattern character into its kind and extracts the digit value
// ----------------------------------------------------------------------------
module lrle_classify (
   input  logic [lrle_pkg::BYTE_BITS-1:0] data_byte,
   output lrle_pkg::char_class_type       char_class
);

   always_comb begin
      char_class.digit = lrle_pkg::DIGIT_BITS'(data_byte - lrle_pkg::CHAR_ZERO);
      priority if (data_byte == lrle_pkg::CHAR_SPACE || data_byte == lrle_pkg::CHAR_TAB ||
                   data_byte == lrle_pkg::CHAR_CR || data_byte == lrle_pkg::CHAR_LF) begin
         char_class.kind = lrle_pkg::KIND_SPACE;
      end else if (data_byte >= lrle_pkg::CHAR_ZERO && data_byte <= lrle_pkg::CHAR_NINE) begin
         char_class.kind = lrle_pkg::KIND_DIGIT;
      end else if (data_byte == lrle_pkg::CHAR_DEAD || data_byte == lrle_pkg::CHAR_DOT) begin
         char_class.kind = lrle_pkg::KIND_BLANK;
      end else if (data_byte == lrle_pkg::CHAR_ALIVE ||
                   data_byte == lrle_pkg::CHAR_UPPER_A) begin
         char_class.kind = lrle_pkg::KIND_COUNTED;
      end else if (data_byte == lrle_pkg::CHAR_ROW) begin
         char_class.kind = lrle_pkg::KIND_NEWROW;
      end else if (data_byte == lrle_pkg::CHAR_END) begin
         char_class.kind = lrle_pkg::KIND_END;
      end else if (data_byte >= lrle_pkg::CHAR_UPPER_B &&
                   data_byte <= lrle_pkg::CHAR_UPPER_Z) begin
         char_class.kind = lrle_pkg::KIND_UNCOUNTED;
      end else begin
         char_class.kind = lrle_pkg::KIND_OTHER;
      end
   end

endmodule

[src/lrle_core.sv]
// ----------------------------------------------------------------------------
// lrle_core
// decoder state (count, cursor, live total, done) and per-character update
// ----------------------------------------------------------------------------
module lrle_core #(
   parameter int COORD_BITS = lrle_pkg::DEFAULT_COORD_BITS,
   parameter int COUNT_BITS = lrle_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_valid,
   input  lrle_pkg::char_class_type            char_class,
   input  logic                                step_last,
   input  logic [lrle_pkg::TOTAL_BITS-1:0]     live_limit,
   output logic                                emit,
   output lrle_pkg::event_type                 event_res,
   output logic [COORD_BITS-1:0]               run_x,
   output logic [COORD_BITS-1:0]               run_y,
   output logic [COUNT_BITS-1:0]               run_length,
   output logic [lrle_pkg::TOTAL_BITS-1:0]     live_total
);

   localparam int XW = ((COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS) + 1;
   localparam int PW = COUNT_BITS + lrle_pkg::DIGIT_BITS;
   localparam int LW = lrle_pkg::TOTAL_BITS + 1;

   logic [COUNT_BITS-1:0]           pending_ff, pending_in;
   logic [COORD_BITS-1:0]           cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]           cursor_y_ff, cursor_y_in;
   logic [lrle_pkg::TOTAL_BITS-1:0] live_seen_ff, live_seen_in;
   logic                            done_ff, done_in;

   logic [COUNT_BITS-1:0]           count;
   logic [PW-1:0]                   digit_sum;
   logic [COUNT_BITS-1:0]           digit_next;
   logic [XW-1:0]                   x_sum, y_sum;
   logic [COORD_BITS-1:0]           x_adv, y_adv;
   logic [LW-1:0]                   live_sum;
   logic [lrle_pkg::TOTAL_BITS-1:0] live_add;

   // an empty count means a run of one
   assign count = (pending_ff == '0) ? COUNT_BITS'(1) : pending_ff;

   assign digit_sum  = PW'(pending_ff) * PW'(lrle_pkg::RADIX) + PW'(char_class.digit);
   assign digit_next = (digit_sum[PW-1:COUNT_BITS] != '0) ? '1 : digit_sum[COUNT_BITS-1:0];

   assign x_sum = XW'(cursor_x_ff) + XW'(count);
   assign y_sum = XW'(cursor_y_ff) + XW'(count);
   assign x_adv = (x_sum[XW-1:COORD_BITS] != '0) ? '1 : x_sum[COORD_BITS-1:0];
   assign y_adv = (y_sum[XW-1:COORD_BITS] != '0) ? '1 : y_sum[COORD_BITS-1:0];

   assign live_sum = LW'(live_seen_ff) + LW'(count);
   assign live_add = live_sum[LW-1] ? '1 : live_sum[lrle_pkg::TOTAL_BITS-1:0];

   always_comb begin
      pending_in   = pending_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      live_seen_in = live_seen_ff;
      done_in      = done_ff;
      emit         = 1'b0;
      event_res    = lrle_pkg::EV_RUN;
      run_x        = '0;
      run_y        = '0;
      run_length   = '0;
      if (step_valid && !done_ff) begin
         unique case (char_class.kind)
            lrle_pkg::KIND_SPACE: begin
            end
            lrle_pkg::KIND_DIGIT: begin
               pending_in = digit_next;
            end
            lrle_pkg::KIND_BLANK: begin
               pending_in = '0;
               if (live_seen_ff <= live_limit) cursor_x_in = x_adv;
            end
            lrle_pkg::KIND_COUNTED: begin
               pending_in   = '0;
               live_seen_in = live_add;
               // compare against the updated total
               if (live_add < live_limit) begin
                  emit        = 1'b1;
                  run_x       = cursor_x_ff;
                  run_y       = cursor_y_ff;
                  run_length  = count;
                  cursor_x_in = x_adv;
               end
            end
            lrle_pkg::KIND_UNCOUNTED: begin
               pending_in  = '0;
               emit        = 1'b1;
               run_x       = cursor_x_ff;
               run_y       = cursor_y_ff;
               run_length  = count;
               cursor_x_in = x_adv;
            end
            lrle_pkg::KIND_NEWROW: begin
               pending_in = '0;
               if (live_seen_ff < live_limit) begin
                  cursor_y_in = y_adv;
                  cursor_x_in = '0;
               end
            end
            lrle_pkg::KIND_END: begin
               pending_in = '0;
               done_in    = 1'b1;
               emit       = 1'b1;
               event_res  = (live_seen_ff >= live_limit) ? lrle_pkg::EV_TOO_MANY
                                                         : lrle_pkg::EV_OK;
            end
            default: begin
               pending_in = '0;
            end
         endcase
         // final byte without terminator replaces any run with a status
         if (step_last && char_class.kind != lrle_pkg::KIND_END) begin
            done_in    = 1'b1;
            emit       = 1'b1;
            event_res  = lrle_pkg::EV_NO_END;
            run_x      = '0;
            run_y      = '0;
            run_length = '0;
         end
      end
   end

   assign live_total = live_seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         live_seen_ff <= '0;
         done_ff      <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         live_seen_ff <= live_seen_in;
         done_ff      <= done_in;
      end
   end

endmodule
